// File: hw/rtl/smf_pkg.sv
// smf_pkg: shared types and constants for the substring match finder
// no dependencies; used by smf_cell, substring_match_finder and smf_checker
`default_nettype none

package smf_pkg;

  // fixed field widths
  localparam int KIND_BITS  = 2;
  localparam int DATA_BITS  = 8;
  localparam int MATCH_BITS = 32;

  // parameter defaults for the top level
  localparam int PATTERN_MAX_DEF   = 256;
  localparam int POSITION_BITS_DEF = 32;

  // item kinds
  typedef enum logic [KIND_BITS-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2
  } kind_t;

  // per-transfer controls broadcast to every cell
  typedef struct packed {
    logic text_step;  // nonzero text byte advances the partial matches
    logic flush;      // clear item or end of document
    logic append;     // pattern byte is written at the current length
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/substring_match_finder.sv
// Substring match finder. Loads a pattern of up to PATTERN_MAX bytes (append items; zero
// bytes and bytes beyond capacity are dropped), then scans text bytes and reports the start
// offset of every occurrence, overlaps included; an empty pattern matches at every text byte.
// A clear item empties the pattern and restarts the offset; a zero text byte ends the document
// and restarts the offset without a result. One item is taken every cycle while the output
// register is empty or being drained; a result is registered in the output register in the
// cycle after its text byte is taken. The row of PATTERN_MAX cells all update their
// partial-match bits from their left neighbor in the same cycle. The offset counter is
// POSITION_BITS wide and wraps; match_start shows its low 32 bits.
// depends on smf_pkg and smf_cell
`default_nettype none

module substring_match_finder #(
  parameter int PATTERN_MAX   = smf_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_BITS = smf_pkg::POSITION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [smf_pkg::KIND_BITS-1:0]  kind,
  input  wire logic [smf_pkg::DATA_BITS-1:0]  data_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [smf_pkg::MATCH_BITS-1:0]      match_start
);
  import smf_pkg::*;

  localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

  logic                     in_xfer;
  cell_ctrl_t               ctrl;
  logic [LEN_BITS-1:0]      pattern_len;
  logic [POSITION_BITS-1:0] text_pos;
  logic [POSITION_BITS-1:0] start_pos;
  logic [PATTERN_MAX-1:0]   match_bits;
  logic [PATTERN_MAX-1:0]   cell_hits;
  logic                     hit;

  // output register frees the input side when empty or draining
  assign in_ready = ~out_valid | out_ready;
  assign in_xfer  = in_valid & in_ready;

  // item decode
  always_comb begin
    ctrl = '0;
    if (in_xfer) begin
      unique case (kind)
        KIND_CLEAR: begin
          ctrl.flush = 1'b1;
        end
        KIND_APPEND: begin
          ctrl.append = (data_byte != '0) && (pattern_len < LEN_BITS'(PATTERN_MAX));
        end
        KIND_TEXT: begin
          ctrl.flush     = (data_byte == '0);
          ctrl.text_step = (data_byte != '0);
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  // pattern length
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= '0;
    end else if (in_xfer && kind == KIND_CLEAR) begin
      pattern_len <= '0;
    end else if (ctrl.append) begin
      pattern_len <= pattern_len + LEN_BITS'(1);
    end
  end

  // text offset
  always_ff @(posedge clk) begin
    if (rst) begin
      text_pos <= '0;
    end else if (ctrl.flush) begin
      text_pos <= '0;
    end else if (ctrl.text_step) begin
      text_pos <= text_pos + POSITION_BITS'(1);
    end
  end

  // row of cells, each fed by its left neighbor
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic prev_bit;
    if (i == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_body
      assign prev_bit = match_bits[i-1];
    end

    smf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .data_byte (data_byte),
      .active    (LEN_BITS'(i) < pattern_len),
      .last      (pattern_len == LEN_BITS'(i + 1)),
      .wr_sel    (pattern_len == LEN_BITS'(i)),
      .prev_bit  (prev_bit),
      .match_bit (match_bits[i]),
      .hit       (cell_hits[i])
    );
  end

  // completed match and its start offset
  assign hit       = (pattern_len == '0) | (|cell_hits);
  assign start_pos = (pattern_len == '0) ? text_pos
                   : text_pos + POSITION_BITS'(1) - POSITION_BITS'(pattern_len);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= ctrl.text_step & hit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && ctrl.text_step) begin
      match_start <= MATCH_BITS'(start_pos);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/smf_cell.sv
// smf_cell: one pattern position; holds a pattern byte and its partial-match bit
// depends on smf_pkg; chained by substring_match_finder
`default_nettype none

module smf_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire smf_pkg::cell_ctrl_t           ctrl,
  input  wire logic [smf_pkg::DATA_BITS-1:0] data_byte,
  input  wire logic                          active,    // position lies inside the pattern
  input  wire logic                          last,      // position is the final pattern byte
  input  wire logic                          wr_sel,    // position is the next one to load
  input  wire logic                          prev_bit,  // partial bit of the left neighbor
  output logic                               match_bit,
  output logic                               hit
);
  import smf_pkg::*;

  logic [DATA_BITS-1:0] pattern_byte;
  logic                 match_bit_next;

  // prefix extends by one when the neighbor matched and this byte agrees
  assign match_bit_next = active & prev_bit & (pattern_byte == data_byte);
  assign hit            = match_bit_next & last;

  // partial-match bit
  always_ff @(posedge clk) begin
    if (rst) begin
      match_bit <= 1'b0;
    end else if (ctrl.flush) begin
      match_bit <= 1'b0;
    end else if (ctrl.text_step) begin
      match_bit <= match_bit_next;
    end
  end

  // pattern byte load
  always_ff @(posedge clk) begin
    if (ctrl.append && wr_sel) begin
      pattern_byte <= data_byte;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/smf_checker.sv
// smf_checker: port-level assertions for substring_match_finder
// depends on smf_pkg; attached to the top level by the bind at the end
`default_nettype none

module smf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [smf_pkg::KIND_BITS-1:0] kind,
  input wire logic [smf_pkg::DATA_BITS-1:0] data_byte,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [smf_pkg::MATCH_BITS-1:0] match_start
);
  import smf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_start))
    else $error("result changed while stalled");

  // an empty output register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a fresh result comes only from a transfer of a nonzero text byte
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid && !out_ready) |->
      $past(in_valid && in_ready && kind == KIND_TEXT && data_byte != '0))
    else $error("result without a text byte");

  // clear items, append items and document ends give no result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_CLEAR || kind == KIND_APPEND ||
      (kind == KIND_TEXT && data_byte == '0)) |=> !out_valid)
    else $error("result from a non-text transfer");

endmodule

bind substring_match_finder smf_checker u_smf_checker (.*);

`default_nettype wire
